@@ rtl/core/gbnwc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gbnwc_pkg;

    localparam int DEF_MAX_WINDOW = 64;

    localparam int SEQ_W     = 32;
    localparam int CNT_W     = 7;
    localparam int WAIT_W    = 8;
    localparam int WIN_W     = 7;
    localparam int KIND_W    = 3;
    localparam int ACT_W     = 3;
    localparam int NACK_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [SEQ_W-1:0]  RST_INIT_SEQ    = '0;
    localparam logic [WAIT_W-1:0] RST_QUEUE_LIMIT = 8'd16;
    localparam logic [WIN_W-1:0]  RST_GROWTH_THR  = 7'd32;
    localparam logic [WIN_W-1:0]  RST_WINDOW      = 7'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_SUBMIT = 3'd0,
        KIND_ACK    = 3'd1,
        KIND_DATA   = 3'd2,
        KIND_RETX   = 3'd3,
        KIND_DELACK = 3'd4
    } kind_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE     = 3'd0,
        ACT_XMIT     = 3'd1,
        ACT_RETX     = 3'd2,
        ACT_SEND_ACK = 3'd3,
        ACT_DELIVER  = 3'd4,
        ACT_REFUSED  = 3'd5
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INIT_SEQ    = 2'd0,
        CFG_QUEUE_LIMIT = 2'd1,
        CFG_GROWTH_THR  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic ev_load;
        logic exec;
        logic mem_rd;
        logic scan_chk;
        logic scan_done;
        logic emit_none;
        logic refill;
        logic grow;
        logic retx_out;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              full;
        logic              flight_empty;
        logic              scan_end;
        logic              keep_eq_count;
        logic              fill_last;
        logic              retx_last;
        logic              slot_free;
    } stat_t;

endpackage

`default_nettype wire

@@ rtl/core/gbnwc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface gbnwc_evt_if
    import gbnwc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  packet_seq;
    logic [SEQ_W-1:0]  ack_number;

    modport source (output valid, kind, packet_seq, ack_number, input ready);
    modport sink   (input valid, kind, packet_seq, ack_number, output ready);
endinterface

interface gbnwc_res_if
    import gbnwc_pkg::*;
();
    logic             valid;
    logic             ready;
    action_t          action;
    logic [SEQ_W-1:0] number;
    logic             restart_xmit_timer;
    logic             restart_delack_timer;
    logic             last;

    modport source (output valid, action, number, restart_xmit_timer,
                    restart_delack_timer, last, input ready);
    modport sink   (input valid, action, number, restart_xmit_timer,
                    restart_delack_timer, last, output ready);
endinterface

interface gbnwc_cfg_if
    import gbnwc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SEQ_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/gbnwc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gbnwc_ctrl
    import gbnwc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  evt_valid,
    output logic       evt_ready,
    input  wire stat_t st,
    output cmd_t       cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_EXEC     = 9'b000000010,
        S_SCAN_RD  = 9'b000000100,
        S_SCAN_CHK = 9'b000001000,
        S_NONE     = 9'b000010000,
        S_REFILL   = 9'b000100000,
        S_GROW     = 9'b001000000,
        S_RETX_RD  = 9'b010000000,
        S_RETX_OUT = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        evt_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                evt_ready = 1'b1;
                if (evt_valid)
                begin
                    cmd.ev_load = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (st.slot_free)
                begin
                    cmd.exec = 1'b1;
                    case (st.kind)
                        KIND_SUBMIT: state_next = st.full ? S_IDLE : S_REFILL;
                        KIND_ACK:    state_next = S_SCAN_RD;
                        KIND_RETX:   state_next = st.flight_empty ? S_IDLE : S_RETX_RD;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                if (st.scan_end)
                begin
                    cmd.scan_done = 1'b1;
                    state_next    = st.keep_eq_count ? S_NONE : S_REFILL;
                end
                else
                begin
                    cmd.mem_rd = 1'b1;
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                cmd.scan_chk = 1'b1;
                state_next   = S_SCAN_RD;
            end
            S_NONE:
            begin
                if (st.slot_free)
                begin
                    cmd.emit_none = 1'b1;
                    state_next    = S_GROW;
                end
            end
            S_REFILL:
            begin
                if (st.slot_free)
                begin
                    cmd.refill = 1'b1;
                    if (st.fill_last)
                    begin
                        state_next = (st.kind == KIND_ACK) ? S_GROW : S_IDLE;
                    end
                end
            end
            S_GROW:
            begin
                cmd.grow   = 1'b1;
                state_next = S_IDLE;
            end
            S_RETX_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_RETX_OUT;
            end
            S_RETX_OUT:
            begin
                if (st.slot_free)
                begin
                    cmd.retx_out = 1'b1;
                    state_next   = st.retx_last ? S_IDLE : S_RETX_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/gbnwc_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gbnwc_dpath
    import gbnwc_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cmd_t                 cmd,
    output stat_t                     st,
    input  wire logic [KIND_W-1:0]    evt_kind,
    input  wire logic [SEQ_W-1:0]     evt_packet_seq,
    input  wire logic [SEQ_W-1:0]     evt_ack_number,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SEQ_W-1:0]     cfg_data,
    input  wire logic                 res_ready,
    output logic                      res_valid,
    output action_t                   res_action,
    output logic [SEQ_W-1:0]          res_number,
    output logic                      res_xmit,
    output logic                      res_delack,
    output logic                      res_last
);

    localparam int AW = $clog2(MAX_WINDOW);
    localparam logic [CNT_W:0] DEPTH = (CNT_W+1)'(MAX_WINDOW);
    localparam logic [WIN_W:0] WIN_CAP = (WIN_W+1)'(MAX_WINDOW);
    localparam logic [WIN_W:0] WIN_JUMP = (WIN_W+1)'(16);
    localparam logic [WIN_W:0] WIN_STEP = (WIN_W+1)'(2);
    // floor(n/5) == (n*205)>>10 for n < 512
    localparam logic [7:0] DIV5_RECIP = 8'd205;
    localparam int DIV5_SHIFT = 10;
    localparam logic [NACK_W-1:0] NACK_MAX = 2'd3;
    localparam logic [NACK_W-1:0] NACK_ACK_FROM = 2'd2;

    function automatic logic [WIN_W-1:0] grow_win(input logic [WIN_W-1:0] w,
                                                  input logic [WIN_W-1:0] thr);
        logic [WIN_W:0] g;
        if (w == WIN_W'(1))
            g = WIN_JUMP;
        else if (w <= thr)
            g = {w, 1'b0};
        else
            g = {1'b0, w} + WIN_STEP;
        if (g >= WIN_CAP)
            g = WIN_CAP;
        return g[WIN_W-1:0];
    endfunction

    function automatic logic [WIN_W-1:0] shrink_win(input logic [WIN_W-1:0] w);
        logic [WIN_W+1:0]  n;
        logic [WIN_W+9:0]  p;
        logic [WIN_W-1:0]  q;
        n = {w, 2'b00};
        p = n * DIV5_RECIP;
        q = p[DIV5_SHIFT +: WIN_W];
        if (q == '0)
            q = WIN_W'(1);
        return q;
    endfunction

    logic [KIND_W-1:0] ev_kind_reg, ev_kind_next;
    logic [SEQ_W-1:0]  ev_pseq_reg, ev_pseq_next;
    logic [SEQ_W-1:0]  ev_ack_reg, ev_ack_next;

    logic [SEQ_W-1:0]  init_seq_reg, init_seq_next;
    logic [WAIT_W-1:0] limit_reg, limit_next;
    logic [WIN_W-1:0]  thr_reg, thr_next;

    logic [SEQ_W-1:0]  next_seq_reg, next_seq_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic [WIN_W-1:0]  win_reg, win_next;
    logic [SEQ_W-1:0]  lio_reg, lio_next;
    logic [NACK_W-1:0] nack_reg, nack_next;
    logic              peer_reg, peer_next;
    logic              have_reg, have_next;
    logic              rx_reg, rx_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  keep_reg, keep_next;

    logic              out_valid_reg, out_valid_next;
    action_t           out_action_reg, out_action_next;
    logic [SEQ_W-1:0]  out_number_reg, out_number_next;
    logic              out_xmit_reg, out_xmit_next;
    logic              out_delack_reg, out_delack_next;
    logic              out_last_reg, out_last_next;

    logic [SEQ_W-1:0]  mem [MAX_WINDOW];
    logic [SEQ_W-1:0]  rdata_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [SEQ_W-1:0]  mem_wdata;

    logic              can_fill;
    logic              can_fill_next;
    logic              fill_last;
    logic              retx_last;
    logic              data_in_order;
    logic [NACK_W-1:0] nack_sat;
    logic [SEQ_W-1:0]  fill_seq;
    logic              slot_free;

    assign slot_free     = !out_valid_reg || res_ready;
    assign can_fill      = (count_reg < win_reg) && ({1'b0, count_reg} < DEPTH)
                           && (wait_reg != '0);
    assign can_fill_next = (({1'b0, count_reg} + 1'b1) < {1'b0, win_reg})
                           && (({1'b0, count_reg} + 1'b1) < DEPTH)
                           && (wait_reg != WAIT_W'(1));
    assign fill_last     = !can_fill || !can_fill_next;
    assign retx_last     = (({1'b0, idx_reg} + 1'b1) == {1'b0, count_reg});
    assign data_in_order = !have_reg || (ev_pseq_reg == lio_reg + 1'b1);
    assign nack_sat      = (nack_reg == NACK_MAX) ? nack_reg : nack_reg + 1'b1;
    assign fill_seq      = next_seq_reg - {{(SEQ_W-WAIT_W){1'b0}}, wait_reg};

    always_comb
    begin
        st.kind          = ev_kind_reg;
        st.full          = (wait_reg >= limit_reg);
        st.flight_empty  = (count_reg == '0);
        st.scan_end      = (idx_reg >= count_reg);
        st.keep_eq_count = (keep_reg == count_reg);
        st.fill_last     = fill_last;
        st.retx_last     = retx_last;
        st.slot_free     = slot_free;
    end

    always_comb
    begin
        ev_kind_next    = ev_kind_reg;
        ev_pseq_next    = ev_pseq_reg;
        ev_ack_next     = ev_ack_reg;
        init_seq_next   = init_seq_reg;
        limit_next      = limit_reg;
        thr_next        = thr_reg;
        next_seq_next   = next_seq_reg;
        count_next      = count_reg;
        wait_next       = wait_reg;
        win_next        = win_reg;
        lio_next        = lio_reg;
        nack_next       = nack_reg;
        peer_next       = peer_reg;
        have_next       = have_reg;
        rx_next         = rx_reg;
        idx_next        = idx_reg;
        keep_next       = keep_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        out_action_next = out_action_reg;
        out_number_next = out_number_reg;
        out_xmit_next   = out_xmit_reg;
        out_delack_next = out_delack_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[AW-1:0];
        mem_wdata       = fill_seq;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INIT_SEQ:
                begin
                    init_seq_next = cfg_data;
                    if (count_reg == '0 && wait_reg == '0)
                        next_seq_next = cfg_data;
                end
                CFG_QUEUE_LIMIT: limit_next = cfg_data[WAIT_W-1:0];
                CFG_GROWTH_THR:  thr_next   = cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end

        if (cmd.ev_load)
        begin
            ev_kind_next = evt_kind;
            ev_pseq_next = evt_packet_seq;
            ev_ack_next  = evt_ack_number;
        end

        if (cmd.exec)
        begin
            case (ev_kind_reg)
                KIND_SUBMIT:
                begin
                    if (wait_reg >= limit_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_action_next = ACT_REFUSED;
                        out_number_next = '0;
                        out_xmit_next   = 1'b0;
                        out_delack_next = 1'b0;
                        out_last_next   = 1'b1;
                    end
                    else
                    begin
                        next_seq_next = next_seq_reg + 1'b1;
                        wait_next     = wait_reg + 1'b1;
                        rx_next       = (count_reg == '0);
                    end
                end
                KIND_ACK:
                begin
                    peer_next = 1'b1;
                    idx_next  = '0;
                    keep_next = '0;
                    rx_next   = 1'b0;
                end
                KIND_DATA:
                begin
                    peer_next       = 1'b1;
                    out_valid_next  = 1'b1;
                    out_xmit_next   = 1'b0;
                    out_last_next   = 1'b1;
                    if (data_in_order)
                    begin
                        have_next       = 1'b1;
                        lio_next        = ev_pseq_reg;
                        nack_next       = '0;
                        out_action_next = ACT_DELIVER;
                        out_number_next = ev_pseq_reg;
                        out_delack_next = 1'b1;
                    end
                    else
                    begin
                        nack_next       = nack_sat;
                        out_delack_next = 1'b0;
                        if (nack_sat >= NACK_ACK_FROM)
                        begin
                            out_action_next = ACT_SEND_ACK;
                            out_number_next = lio_reg;
                        end
                        else
                        begin
                            out_action_next = ACT_NONE;
                            out_number_next = '0;
                        end
                    end
                end
                KIND_RETX:
                begin
                    if (count_reg != '0)
                    begin
                        win_next = shrink_win(win_reg);
                        idx_next = '0;
                    end
                    else
                    begin
                        out_valid_next  = 1'b1;
                        out_action_next = ACT_NONE;
                        out_number_next = '0;
                        out_xmit_next   = 1'b0;
                        out_delack_next = 1'b0;
                        out_last_next   = 1'b1;
                    end
                end
                KIND_DELACK:
                begin
                    out_valid_next  = 1'b1;
                    out_xmit_next   = 1'b0;
                    out_delack_next = 1'b0;
                    out_last_next   = 1'b1;
                    if (peer_reg && have_reg)
                    begin
                        out_action_next = ACT_SEND_ACK;
                        out_number_next = lio_reg;
                    end
                    else
                    begin
                        out_action_next = ACT_NONE;
                        out_number_next = '0;
                    end
                end
                default:
                begin
                    out_valid_next  = 1'b1;
                    out_action_next = ACT_NONE;
                    out_number_next = '0;
                    out_xmit_next   = 1'b0;
                    out_delack_next = 1'b0;
                    out_last_next   = 1'b1;
                end
            endcase
        end

        // compaction: keep entries above the ack number, in order
        if (cmd.scan_chk)
        begin
            if (rdata_reg > ev_ack_reg)
            begin
                mem_we    = 1'b1;
                mem_waddr = keep_reg[AW-1:0];
                mem_wdata = rdata_reg;
                keep_next = keep_reg + 1'b1;
            end
            idx_next = idx_reg + 1'b1;
        end

        if (cmd.scan_done)
        begin
            count_next = keep_reg;
            rx_next    = (keep_reg != count_reg) && (keep_reg == '0) && (wait_reg != '0);
        end

        if (cmd.emit_none)
        begin
            out_valid_next  = 1'b1;
            out_action_next = ACT_NONE;
            out_number_next = '0;
            out_xmit_next   = rx_reg;
            out_delack_next = 1'b0;
            out_last_next   = 1'b1;
        end

        if (cmd.refill)
        begin
            out_valid_next  = 1'b1;
            out_delack_next = 1'b0;
            out_last_next   = fill_last;
            out_xmit_next   = fill_last && rx_reg;
            if (can_fill)
            begin
                mem_we          = 1'b1;
                count_next      = count_reg + 1'b1;
                wait_next       = wait_reg - 1'b1;
                out_action_next = ACT_XMIT;
                out_number_next = fill_seq;
            end
            else
            begin
                out_action_next = ACT_NONE;
                out_number_next = '0;
            end
        end

        if (cmd.grow)
        begin
            win_next = grow_win(win_reg, thr_reg);
        end

        if (cmd.retx_out)
        begin
            out_valid_next  = 1'b1;
            out_action_next = ACT_RETX;
            out_number_next = rdata_reg;
            out_xmit_next   = retx_last;
            out_delack_next = 1'b0;
            out_last_next   = retx_last;
            idx_next        = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_seq_reg  <= RST_INIT_SEQ;
            limit_reg     <= RST_QUEUE_LIMIT;
            thr_reg       <= RST_GROWTH_THR;
            next_seq_reg  <= RST_INIT_SEQ;
            count_reg     <= '0;
            wait_reg      <= '0;
            win_reg       <= RST_WINDOW;
            lio_reg       <= '0;
            nack_reg      <= '0;
            peer_reg      <= 1'b0;
            have_reg      <= 1'b0;
            rx_reg        <= 1'b0;
            idx_reg       <= '0;
            keep_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            init_seq_reg  <= init_seq_next;
            limit_reg     <= limit_next;
            thr_reg       <= thr_next;
            next_seq_reg  <= next_seq_next;
            count_reg     <= count_next;
            wait_reg      <= wait_next;
            win_reg       <= win_next;
            lio_reg       <= lio_next;
            nack_reg      <= nack_next;
            peer_reg      <= peer_next;
            have_reg      <= have_next;
            rx_reg        <= rx_next;
            idx_reg       <= idx_next;
            keep_reg      <= keep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ev_kind_reg    <= ev_kind_next;
        ev_pseq_reg    <= ev_pseq_next;
        ev_ack_reg     <= ev_ack_next;
        out_action_reg <= out_action_next;
        out_number_reg <= out_number_next;
        out_xmit_reg   <= out_xmit_next;
        out_delack_reg <= out_delack_next;
        out_last_reg   <= out_last_next;
    end

    // flight list
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (cmd.mem_rd)
            rdata_reg <= mem[idx_reg[AW-1:0]];
    end

    assign res_valid  = out_valid_reg;
    assign res_action = out_action_reg;
    assign res_number = out_number_reg;
    assign res_xmit   = out_xmit_reg;
    assign res_delack = out_delack_reg;
    assign res_last   = out_last_reg;

endmodule

`default_nettype wire

@@ rtl/core/go_back_n_window_controller_top.sv @@
// Go-back-N send/receive sequencer. Each event on evt yields one or more
// requests on res, the final one flagged by last and carrying the timer
// restarts. Data, delayed-ack, refused submit and unknown events and a
// retransmit timeout with nothing in flight yield a single result. A
// submit yields one result per transmit, or one when nothing is sent. An
// ack scans the flight list held in a single-port memory with registered
// read: each in-flight packet is read and then checked, the scan is
// closed, then come the refill transmits (one result if none) and window
// growth. A retransmit timeout reads and resends each packet in flight. A
// result waiting on res stalls further work but not acceptance of the next
// event. No clearing pass after reset; configuration is always ready.
`timescale 1ns / 1ps
`default_nettype none

module go_back_n_window_controller_top
    import gbnwc_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    gbnwc_evt_if.sink   evt,
    gbnwc_cfg_if.sink   cfg,
    gbnwc_res_if.source res
);

    cmd_t  cmd;
    stat_t st;

    assign cfg.ready = 1'b1;

    gbnwc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt.valid),
        .evt_ready (evt.ready),
        .st        (st),
        .cmd       (cmd)
    );

    gbnwc_dpath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .st             (st),
        .evt_kind       (evt.kind),
        .evt_packet_seq (evt.packet_seq),
        .evt_ack_number (evt.ack_number),
        .cfg_valid      (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .res_ready      (res.ready),
        .res_valid      (res.valid),
        .res_action     (res.action),
        .res_number     (res.number),
        .res_xmit       (res.restart_xmit_timer),
        .res_delack     (res.restart_delack_timer),
        .res_last       (res.last)
    );

endmodule

`default_nettype wire

@@ test/go_back_n_window_controller_top_tb.sv @@
`timescale 1ns / 1ps

module go_back_n_window_controller_top_tb;
    import gbnwc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned FLIGHT_SLOTS   = DEF_MAX_WINDOW;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  packet_seq;
        logic [SEQ_W-1:0]  ack_number;
    } link_event_t;

    typedef struct packed {
        action_t          action;
        logic [SEQ_W-1:0] number;
        logic             restart_xmit_timer;
        logic             restart_delack_timer;
        logic             last;
    } result_t;

    logic clk;
    logic rst_n;

    // stimulus and checking bookkeeping
    link_event_t pending_events[$];
    result_t     expected_results[$];
    int unsigned events_offered = 0;
    int unsigned events_taken   = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned send_gap       = 0;
    int unsigned sink_stall     = 0;
    bit          idling         = 1'b1;

    // link state as the block should hold it
    logic [WAIT_W-1:0] queue_limit    = RST_QUEUE_LIMIT;
    logic [WIN_W-1:0]  growth_thr     = RST_GROWTH_THR;
    logic [SEQ_W-1:0]  tx_next_number = RST_INIT_SEQ;
    int unsigned       flight_count   = 0;
    int unsigned       waiting_count  = 0;
    int unsigned       cwnd           = 1;
    logic [SEQ_W-1:0]  rx_last_seq    = '0;
    int unsigned       nack_count     = 0;
    bit                peer_known     = 1'b0;
    bit                rx_started     = 1'b0;
    logic [SEQ_W-1:0]  flight_seq [FLIGHT_SLOTS];
    int unsigned       event_result_count;
    bit                xmit_restart;

    function automatic void note_result(action_t act, logic [SEQ_W-1:0] num);
        result_t r;
        r = '0;
        r.action = act;
        r.number = num;
        expected_results.push_back(r);
        event_result_count++;
    endfunction

    function automatic void refill_flight();
        logic [SEQ_W-1:0] s;
        if (waiting_count == 0)
            return;
        if (flight_count == 0)
            xmit_restart = 1'b1;
        while (flight_count < cwnd && flight_count < FLIGHT_SLOTS && waiting_count > 0)
        begin
            s = tx_next_number - waiting_count;
            flight_seq[flight_count] = s;
            flight_count++;
            waiting_count--;
            note_result(ACT_XMIT, s);
        end
    endfunction

    function automatic void predict_event(link_event_t ev);
        int unsigned kept;
        bit          delack_restart;
        result_t     tail;
        event_result_count = 0;
        xmit_restart = 1'b0;
        delack_restart = 1'b0;
        case (ev.kind)
            KIND_SUBMIT:
            begin
                if (waiting_count >= queue_limit)
                begin
                    note_result(ACT_REFUSED, '0);
                end
                else
                begin
                    tx_next_number++;
                    waiting_count++;
                    refill_flight();
                end
            end
            KIND_ACK:
            begin
                peer_known = 1'b1;
                kept = 0;
                for (int i = 0; i < flight_count; i++)
                begin
                    if (flight_seq[i] > ev.ack_number)
                    begin
                        flight_seq[kept] = flight_seq[i];
                        kept++;
                    end
                end
                if (kept != flight_count)
                begin
                    flight_count = kept;
                    refill_flight();
                end
                if (cwnd == 1)
                    cwnd = 16;
                else if (cwnd <= growth_thr)
                    cwnd = cwnd * 2;
                else
                    cwnd = cwnd + 2;
                if (cwnd >= DEF_MAX_WINDOW)
                    cwnd = DEF_MAX_WINDOW;
            end
            KIND_DATA:
            begin
                peer_known = 1'b1;
                if (!rx_started || ev.packet_seq == rx_last_seq + 32'd1)
                begin
                    rx_started = 1'b1;
                    rx_last_seq = ev.packet_seq;
                    nack_count = 0;
                    delack_restart = 1'b1;
                    note_result(ACT_DELIVER, ev.packet_seq);
                end
                else
                begin
                    if (nack_count < 3)
                        nack_count++;
                    if (nack_count >= 2)
                        note_result(ACT_SEND_ACK, rx_last_seq);
                end
            end
            KIND_RETX:
            begin
                if (flight_count > 0)
                begin
                    for (int i = 0; i < flight_count; i++)
                        note_result(ACT_RETX, flight_seq[i]);
                    cwnd = cwnd * 4 / 5;
                    if (cwnd < 1)
                        cwnd = 1;
                    xmit_restart = 1'b1;
                end
            end
            KIND_DELACK:
            begin
                if (peer_known && rx_started)
                    note_result(ACT_SEND_ACK, rx_last_seq);
            end
            default:
            begin
            end
        endcase
        if (event_result_count == 0)
            note_result(ACT_NONE, '0);
        tail = expected_results.pop_back();
        tail.restart_xmit_timer = xmit_restart;
        tail.restart_delack_timer = delack_restart;
        tail.last = 1'b1;
        expected_results.push_back(tail);
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [SEQ_W-1:0] value);
        case (idx)
            CFG_INIT_SEQ:
            begin
                if (flight_count == 0 && waiting_count == 0)
                    tx_next_number = value;
            end
            CFG_QUEUE_LIMIT: queue_limit = value[WAIT_W-1:0];
            CFG_GROWTH_THR:  growth_thr = value[WIN_W-1:0];
            default:
            begin
            end
        endcase
    endfunction

    // mostly well-formed traffic: acks near the flight, data mostly in order
    function automatic link_event_t random_event(int unsigned submit_pct);
        link_event_t ev;
        int unsigned pick;
        ev.kind = KIND_SUBMIT;
        ev.packet_seq = $urandom;
        ev.ack_number = $urandom;
        if ($urandom_range(0, 99) >= submit_pct)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                ev.kind = KIND_ACK;
            else if (pick < 75)
                ev.kind = KIND_DATA;
            else if (pick < 85)
                ev.kind = KIND_RETX;
            else if (pick < 95)
                ev.kind = KIND_DELACK;
            else
                ev.kind = KIND_W'($urandom_range(KIND_DELACK + 1, 7));
        end
        pick = $urandom_range(0, 5);
        if (pick == 5)
        begin
            ev.ack_number = tx_next_number - 32'd1;
        end
        else if (pick != 0 && flight_count != 0)
        begin
            ev.ack_number = flight_seq[$urandom_range(0, flight_count - 1)];
            if (pick == 4)
                ev.ack_number = ev.ack_number - 32'd1;
        end
        pick = $urandom_range(0, 9);
        if (pick < 7)
            ev.packet_seq = rx_last_seq + 32'd1;
        else if (pick == 7)
            ev.packet_seq = rx_last_seq;
        return ev;
    endfunction

    gbnwc_evt_if evt_if ();
    gbnwc_res_if res_if ();
    gbnwc_cfg_if cfg_if ();

    go_back_n_window_controller_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_if),
        .cfg   (cfg_if),
        .res   (res_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // request driver
    always @(negedge clk)
    begin
        link_event_t ev;
        if (!rst_n)
        begin
            evt_if.valid <= 1'b0;
        end
        else if (!evt_if.valid || events_taken == events_offered)
        begin
            if (idling && send_gap != 0)
            begin
                send_gap = send_gap - 1;
                evt_if.valid <= 1'b0;
            end
            else if (pending_events.size() != 0)
            begin
                ev = pending_events.pop_front();
                evt_if.valid <= 1'b1;
                evt_if.kind <= ev.kind;
                evt_if.packet_seq <= ev.packet_seq;
                evt_if.ack_number <= ev.ack_number;
                events_offered++;
                if (idling && $urandom_range(0, 4) == 0)
                    send_gap = $urandom_range(1, 15);
            end
            else
            begin
                evt_if.valid <= 1'b0;
            end
        end
    end

    // result backpressure
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
        end
        else if (idling && sink_stall != 0)
        begin
            sink_stall = sink_stall - 1;
            res_if.ready <= 1'b0;
        end
        else
        begin
            res_if.ready <= 1'b1;
            if (idling && $urandom_range(0, 5) == 0)
                sink_stall = $urandom_range(1, 15);
        end
    end

    // monitor: check results, track config writes, predict accepted requests
    always @(posedge clk)
    begin
        result_t     want;
        link_event_t ev;
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: action %0d number %0h",
                           res_if.action, res_if.number);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res_if.action !== want.action)
                    begin
                        $error("action: expected %0d, got %0d", want.action, res_if.action);
                        mismatch_count++;
                    end
                    if (res_if.number !== want.number)
                    begin
                        $error("number: expected %0h, got %0h", want.number, res_if.number);
                        mismatch_count++;
                    end
                    if (res_if.restart_xmit_timer !== want.restart_xmit_timer)
                    begin
                        $error("restart_xmit_timer: expected %0b, got %0b",
                               want.restart_xmit_timer, res_if.restart_xmit_timer);
                        mismatch_count++;
                    end
                    if (res_if.restart_delack_timer !== want.restart_delack_timer)
                    begin
                        $error("restart_delack_timer: expected %0b, got %0b",
                               want.restart_delack_timer, res_if.restart_delack_timer);
                        mismatch_count++;
                    end
                    if (res_if.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, res_if.last);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_if.valid && cfg_if.ready)
                apply_register(cfg_if.index, cfg_if.data);
            if (evt_if.valid && evt_if.ready)
            begin
                ev.kind = evt_if.kind;
                ev.packet_seq = evt_if.packet_seq;
                ev.ack_number = evt_if.ack_number;
                events_taken++;
                predict_event(ev);
            end
            if ((res_if.valid && res_if.ready) || (cfg_if.valid && cfg_if.ready) ||
                (evt_if.valid && evt_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic queue_event(logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] pseq,
                               logic [SEQ_W-1:0] ackn);
        link_event_t ev;
        ev.kind = kind;
        ev.packet_seq = pseq;
        ev.ack_number = ackn;
        pending_events.push_back(ev);
    endtask

    task automatic run_random(int unsigned count, int unsigned submit_pct);
        repeat (count)
        begin
            while (pending_events.size() >= 2)
                @(negedge clk);
            pending_events.push_back(random_event(submit_pct));
        end
    endtask

    // wait until every request is taken and every result is back
    task automatic settle();
        do
            @(negedge clk);
        while (pending_events.size() != 0 || events_taken != events_offered ||
               expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [SEQ_W-1:0] value);
        logic [SEQ_W-1:0] word;
        word = $urandom;
        case (idx)
            CFG_QUEUE_LIMIT: word[WAIT_W-1:0] = value[WAIT_W-1:0];
            CFG_GROWTH_THR:  word[WIN_W-1:0] = value[WIN_W-1:0];
            default:         word = value;
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= word;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    initial
    begin
        evt_if.valid = 1'b0;
        evt_if.kind = KIND_SUBMIT;
        evt_if.packet_seq = '0;
        evt_if.ack_number = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_INIT_SEQ;
        cfg_if.data = '0;
        res_if.ready = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // receive side and idle cases on reset settings
        queue_event(KIND_DELACK, '0, '0);
        queue_event(KIND_RETX, '0, '0);
        for (int k = KIND_DELACK + 1; k < 8; k++)
            queue_event(KIND_W'(k), '1, '1);
        queue_event(KIND_DATA, 32'hFFFF_FFFF, '0);
        queue_event(KIND_DATA, 32'h0000_0000, '0);
        queue_event(KIND_DATA, 32'h0000_0007, '0);
        queue_event(KIND_DATA, 32'h0000_0007, '0);
        queue_event(KIND_DATA, 32'h0000_0000, '0);
        queue_event(KIND_DELACK, '0, '0);
        // send side: window of one, timeout, window growth
        queue_event(KIND_SUBMIT, '0, '0);
        queue_event(KIND_SUBMIT, '0, '0);
        queue_event(KIND_SUBMIT, '0, '0);
        queue_event(KIND_RETX, '0, '0);
        queue_event(KIND_ACK, '0, 32'h0000_0000);
        queue_event(KIND_ACK, '0, 32'h0000_0000);
        queue_event(KIND_RETX, '0, '0);
        queue_event(KIND_ACK, '0, 32'hFFFF_FFFF);
        queue_event(KIND_ACK, '0, 32'hFFFF_FFFF);
        settle();

        write_reg(CFG_QUEUE_LIMIT, 32'd0);
        queue_event(KIND_SUBMIT, '0, '0);
        settle();

        // numbering wraps past the top
        write_reg(CFG_INIT_SEQ, 32'hFFFF_FFFE);
        write_reg(CFG_QUEUE_LIMIT, 32'd255);
        write_reg(CFG_GROWTH_THR, 32'd64);
        queue_event(KIND_SUBMIT, '0, '0);
        queue_event(KIND_SUBMIT, '0, '0);
        queue_event(KIND_SUBMIT, '0, '0);
        queue_event(KIND_ACK, '0, 32'hFFFF_FFFE);
        run_random(60, 40);
        settle();

        write_reg(CFG_INIT_SEQ, 32'hFFFF_FFFF);
        write_reg(CFG_QUEUE_LIMIT, 32'd1);
        write_reg(CFG_GROWTH_THR, 32'd1);
        run_random(60, 75);
        settle();

        write_reg(CFG_INIT_SEQ, 32'd0);
        write_reg(CFG_QUEUE_LIMIT, 32'd3);
        write_reg(CFG_GROWTH_THR, 32'd16);
        run_random(70, 50);
        settle();

        write_reg(CFG_INIT_SEQ, $urandom);
        write_reg(CFG_QUEUE_LIMIT, $urandom_range(1, 255));
        write_reg(CFG_GROWTH_THR, $urandom_range(1, 64));
        run_random(60, 45);
        settle();

        idling = 1'b0;
        write_reg(CFG_INIT_SEQ, $urandom);
        write_reg(CFG_QUEUE_LIMIT, 32'd16);
        write_reg(CFG_GROWTH_THR, 32'd32);
        run_random(60, 40);
        settle();

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
